// ===== hw/rtl/lrcf_pkg.sv =====
// ----------------------------------------------------------------------------
// lrcf_pkg - shared types and constants of the ring clock face
// payload structs, color constants, gamma table and fixed-point widths
// ----------------------------------------------------------------------------
package lrcf_pkg;

   localparam int PIXEL_COUNT        = 60;
   localparam int FADE_STEPS_DEFAULT = 32;
   localparam int PIX_W              = $clog2(PIXEL_COUNT);
   localparam int COLOR_W            = 8;
   localparam int FRAC_W             = 10;
   localparam int LVL_W              = COLOR_W + FRAC_W;
   localparam int NUM_W              = LVL_W + 1;
   localparam int HOUR_W             = 5;
   localparam int MIN_W              = 6;
   localparam int ROT_W              = 6;

   localparam logic [HOUR_W-1:0] HOUR_MAX = 5'd23;
   localparam logic [MIN_W-1:0]  MIN_MAX  = 6'd59;
   localparam logic [PIX_W-1:0]  LAST_PIX = PIX_W'(PIXEL_COUNT - 1);

   localparam logic CMD_SET_TIME = 1'b0;
   localparam logic CMD_STEP     = 1'b1;

   localparam logic CSR_MUTE     = 1'b0;
   localparam logic CSR_ROTATION = 1'b1;

   // channel 2 is red, 1 green, 0 blue
   typedef logic [2:0][COLOR_W-1:0] color_type;
   typedef logic [2:0][LVL_W-1:0]   level_type;

   localparam color_type COL_TOP     = {8'd0,   8'd66,  8'd74};
   localparam color_type COL_QUARTER = {8'd0,   8'd0,   8'd80};
   localparam color_type COL_FIVE    = {8'd0,   8'd0,   8'd61};
   localparam color_type COL_ELEM    = {8'd0,   8'd0,   8'd32};
   localparam color_type COL_HOUR    = {8'd102, 8'd0,   8'd0};
   localparam color_type COL_MINUTE  = {8'd0,   8'd102, 8'd0};
   localparam color_type COL_SECOND  = {8'd92,  8'd85,  8'd0};
   localparam color_type COL_HMS     = {8'd126, 8'd112, 8'd0};
   localparam color_type COL_HM      = {8'd102, 8'd102, 8'd0};
   localparam color_type COL_HS      = {8'd137, 8'd0,   8'd0};
   localparam color_type COL_MS      = {8'd0,   8'd137, 8'd0};

   typedef struct packed {
      logic              command;
      logic [HOUR_W-1:0] hour;
      logic [MIN_W-1:0]  minute;
      logic [MIN_W-1:0]  second;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0]   pixel_index;
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
      logic               last;
   } rsp_type;

   localparam logic [7:0] GAMMA_LUT [256] = '{
      8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,
      8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,
      8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,
      8'd0,  8'd0,  8'd0,  8'd0,  8'd1,  8'd1,  8'd1,  8'd1,
      8'd1,  8'd1,  8'd1,  8'd1,  8'd1,  8'd1,  8'd1,  8'd1,
      8'd1,  8'd2,  8'd2,  8'd2,  8'd2,  8'd2,  8'd2,  8'd2,
      8'd2,  8'd3,  8'd3,  8'd3,  8'd3,  8'd3,  8'd3,  8'd3,
      8'd4,  8'd4,  8'd4,  8'd4,  8'd4,  8'd5,  8'd5,  8'd5,
      8'd5,  8'd6,  8'd6,  8'd6,  8'd6,  8'd7,  8'd7,  8'd7,
      8'd7,  8'd8,  8'd8,  8'd8,  8'd9,  8'd9,  8'd9,  8'd10,
      8'd10, 8'd10, 8'd11, 8'd11, 8'd11, 8'd12, 8'd12, 8'd13,
      8'd13, 8'd13, 8'd14, 8'd14, 8'd15, 8'd15, 8'd16, 8'd16,
      8'd17, 8'd17, 8'd18, 8'd18, 8'd19, 8'd19, 8'd20, 8'd20,
      8'd21, 8'd21, 8'd22, 8'd22, 8'd23, 8'd24, 8'd24, 8'd25,
      8'd25, 8'd26, 8'd27, 8'd27, 8'd28, 8'd29, 8'd29, 8'd30,
      8'd31, 8'd32, 8'd32, 8'd33, 8'd34, 8'd35, 8'd35, 8'd36,
      8'd37, 8'd38, 8'd39, 8'd39, 8'd40, 8'd41, 8'd42, 8'd43,
      8'd44, 8'd45, 8'd46, 8'd47, 8'd48, 8'd49, 8'd50, 8'd50,
      8'd51, 8'd52, 8'd54, 8'd55, 8'd56, 8'd57, 8'd58, 8'd59,
      8'd60, 8'd61, 8'd62, 8'd63, 8'd64, 8'd66, 8'd67, 8'd68,
      8'd69, 8'd70, 8'd72, 8'd73, 8'd74, 8'd75, 8'd77, 8'd78,
      8'd79, 8'd81, 8'd82, 8'd83, 8'd85, 8'd86, 8'd87, 8'd89,
      8'd90, 8'd92, 8'd93, 8'd95, 8'd96, 8'd98, 8'd99, 8'd101,
      8'd102,8'd104,8'd105,8'd107,8'd109,8'd110,8'd112,8'd114,
      8'd115,8'd117,8'd119,8'd120,8'd122,8'd124,8'd126,8'd127,
      8'd129,8'd131,8'd133,8'd135,8'd137,8'd138,8'd140,8'd142,
      8'd144,8'd146,8'd148,8'd150,8'd152,8'd154,8'd156,8'd158,
      8'd160,8'd162,8'd164,8'd167,8'd169,8'd171,8'd173,8'd175,
      8'd177,8'd180,8'd182,8'd184,8'd186,8'd189,8'd191,8'd193,
      8'd196,8'd198,8'd200,8'd203,8'd205,8'd208,8'd210,8'd213,
      8'd215,8'd218,8'd220,8'd223,8'd225,8'd228,8'd231,8'd233,
      8'd236,8'd239,8'd241,8'd244,8'd247,8'd249,8'd252,8'd255
   };

endpackage

// ===== hw/rtl/lrcf_ram.sv =====
// ----------------------------------------------------------------------------
// lrcf_ram - generic simple dual-port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module lrcf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== hw/rtl/lrcf_divider.sv =====
// ----------------------------------------------------------------------------
// lrcf_divider - shared signed divider by a fixed divisor
// one reciprocal multiply reused for the three channels, truncates toward zero
// ----------------------------------------------------------------------------
module lrcf_divider import lrcf_pkg::*; #(
   parameter int DIVISOR = FADE_STEPS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [2:0][NUM_W-1:0]       numer,
   output logic                        done,
   output level_type                   quot
);

   // exact for every magnitude below 2**LVL_W
   localparam int SHIFT  = LVL_W + $clog2(DIVISOR);
   localparam int RCP_W  = LVL_W + 2;
   localparam int PROD_W = LVL_W + RCP_W;
   localparam longint RCP_VAL = ((longint'(1) << SHIFT) + longint'(DIVISOR) - 1)
                                / longint'(DIVISOR);
   localparam logic [RCP_W-1:0] RECIP   = RCP_W'(RCP_VAL);
   localparam logic [1:0]       LAST_CH = 2'd2;

   logic                  busy_ff, done_ff;
   logic [1:0]            ch_ff;
   level_type             mag_ff, quot_ff;
   logic [2:0]            neg_ff;
   logic [2:0][NUM_W-1:0] abs_num;
   logic [LVL_W-1:0]      mag_sel, q_mag;
   logic [PROD_W-1:0]     prod, prod_shr;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         abs_num[c] = numer[c][NUM_W-1] ? -numer[c] : numer[c];
      end
      mag_sel  = mag_ff[ch_ff];
      prod     = {{RCP_W{1'b0}}, mag_sel} * {{LVL_W{1'b0}}, RECIP};
      prod_shr = prod >> SHIFT;
      q_mag    = prod_shr[LVL_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         ch_ff   <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            ch_ff   <= '0;
         end else if (busy_ff) begin
            ch_ff <= ch_ff + 1'b1;
            if (ch_ff == LAST_CH) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         for (int c = 0; c < 3; c++) begin
            mag_ff[c] <= abs_num[c][LVL_W-1:0];
            neg_ff[c] <= numer[c][NUM_W-1];
         end
      end else if (busy_ff) begin
         quot_ff[ch_ff] <= neg_ff[ch_ff] ? -q_mag : q_mag;
      end
   end

   assign quot = quot_ff;
   assign done = done_ff;

endmodule

// ===== hw/rtl/lrcf_face.sv =====
// ----------------------------------------------------------------------------
// lrcf_face - target color of one physical led
// background marks, hands and coincidence colors for the current time
// ----------------------------------------------------------------------------
module lrcf_face import lrcf_pkg::*; (
   input  logic [PIX_W-1:0]  pixel,
   input  logic [ROT_W-1:0]  rotation,
   input  logic [HOUR_W-1:0] hours,
   input  logic [MIN_W-1:0]  minutes,
   input  logic [MIN_W-1:0]  seconds,
   output color_type         color
);

   logic [ROT_W-1:0] rot_eff;
   logic [PIX_W:0]   wrapped;
   logic [PIX_W-1:0] logical;
   logic [3:0]       h12;
   logic [MIN_W-1:0] hpos;
   logic             five_mark;

   always_comb begin
      rot_eff = (rotation >= ROT_W'(PIXEL_COUNT)) ? rotation - ROT_W'(PIXEL_COUNT) : rotation;
      wrapped = {1'b0, pixel} + (PIX_W+1)'(PIXEL_COUNT) - {1'b0, rot_eff};
      logical = (pixel >= rot_eff) ? pixel - rot_eff : wrapped[PIX_W-1:0];
      h12     = (hours >= 5'd12) ? 4'(hours - 5'd12) : hours[3:0];
      hpos    = {h12, 2'b00} + {2'b00, h12};
      five_mark = 1'b0;
      for (int k = 0; k < PIXEL_COUNT / 5; k++) begin
         if (logical == PIX_W'(k * 5)) five_mark = 1'b1;
      end

      if (logical == '0) color = COL_TOP;
      else if (logical == 6'd15 || logical == 6'd30 || logical == 6'd45) color = COL_QUARTER;
      else if (five_mark) color = COL_FIVE;
      else color = COL_ELEM;

      // later hands paint over earlier ones
      if (logical == hpos)    color = COL_HOUR;
      if (logical == minutes) color = COL_MINUTE;
      if (logical == seconds) color = COL_SECOND;
      if (hpos == minutes) begin
         if (minutes == seconds) begin
            if (logical == seconds) color = COL_HMS;
         end else if (logical == minutes) begin
            color = COL_HM;
         end
      end else begin
         if (minutes == seconds && logical == minutes) color = COL_MS;
         if (hpos == seconds && logical == hpos) color = COL_HS;
      end
   end

endmodule

// ===== hw/rtl/led_ring_clock_face_crossfade.sv =====
// ----------------------------------------------------------------------------
// led_ring_clock_face_crossfade - sixty-led ring clock with cross-fades
// sequencer over level and target memories, shared divider for increments
// ----------------------------------------------------------------------------
// A set-time beat gives no result. A step beat walks the sixty pixels one at a
// time through the level memory: a read and a new-level state per pixel when
// muted, plus a result state that waits out any output stall when not, giving
// sixty result beats in led order unless muted. The last step of a fade cycle
// then ticks the clock and walks the pixels a second time to compose the new
// face and divide the remaining distance by FADE_STEPS in the shared divider, a
// reciprocal multiply that handles one channel per cycle; each pixel passes
// through read, divide start, divide and write back there. The block takes no
// request beat while a pass runs.
// After reset the memories read as zero until their first full pass.
// ----------------------------------------------------------------------------
module led_ring_clock_face_crossfade import lrcf_pkg::*; #(
   parameter int FADE_STEPS = FADE_STEPS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  req_type            req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rsp_type            rsp_data,
   input  logic               csr_write,
   input  logic               csr_index,
   input  logic [ROT_W-1:0]   csr_wdata
);

   localparam int STEP_W = $clog2(FADE_STEPS);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(FADE_STEPS - 1);
   localparam int TI_W = 3 * COLOR_W + 3 * LVL_W;

   // sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_URD   = 3'd1;  // update pass: memory read
   localparam logic [2:0] S_UCALC = 3'd2;  // update pass: new level
   localparam logic [2:0] S_UOUT  = 3'd3;  // update pass: result beat
   localparam logic [2:0] S_CRD   = 3'd4;  // compose pass: memory read
   localparam logic [2:0] S_CLD   = 3'd5;  // compose pass: start divide
   localparam logic [2:0] S_CDIV  = 3'd6;  // compose pass: divide
   localparam logic [2:0] S_CWR   = 3'd7;  // compose pass: write back

   logic [2:0]        state_ff, state_in;
   logic [PIX_W-1:0]  pix_ff, pix_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              final_ff, final_in;
   logic              lvl_ok_ff, lvl_ok_in;
   logic              tgt_ok_ff, tgt_ok_in;
   logic              out_valid_ff, out_valid_in;
   logic              mute_ff, mute_in;
   logic [ROT_W-1:0]  rot_ff, rot_in;
   logic [HOUR_W-1:0] hours_ff, hours_in;
   logic [MIN_W-1:0]  minutes_ff, minutes_in;
   logic [MIN_W-1:0]  seconds_ff, seconds_in;
   level_type         out_lvl_ff, out_lvl_in;

   // memories
   level_type         lvl_q, lvl_rd, lvl_new;
   logic              lvl_we;
   logic [TI_W-1:0]   ti_q, ti_rd, ti_wdata;
   logic              ti_we;
   color_type         tgt_rd, face_color;
   level_type         inc_rd;

   // divider
   logic                  div_start, div_done;
   logic [2:0][NUM_W-1:0] div_numer;
   level_type             div_quot;

   lrcf_ram #(.WIDTH(3 * LVL_W), .DEPTH(PIXEL_COUNT)) u_level_ram (
      .clock   (clock),
      .wr_en   (lvl_we),
      .wr_addr (pix_ff),
      .wr_data (lvl_new),
      .rd_addr (pix_ff),
      .rd_data (lvl_q)
   );

   // target color and increment live side by side
   lrcf_ram #(.WIDTH(TI_W), .DEPTH(PIXEL_COUNT)) u_target_ram (
      .clock   (clock),
      .wr_en   (ti_we),
      .wr_addr (pix_ff),
      .wr_data (ti_wdata),
      .rd_addr (pix_ff),
      .rd_data (ti_q)
   );

   lrcf_face u_face (
      .pixel    (pix_ff),
      .rotation (rot_ff),
      .hours    (hours_ff),
      .minutes  (minutes_ff),
      .seconds  (seconds_ff),
      .color    (face_color)
   );

   lrcf_divider #(.DIVISOR(FADE_STEPS)) u_divider (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_numer),
      .done  (div_done),
      .quot  (div_quot)
   );

   // stores read as zero until their first full pass
   assign lvl_rd   = lvl_ok_ff ? lvl_q : '0;
   assign ti_rd    = tgt_ok_ff ? ti_q : '0;
   assign tgt_rd   = ti_rd[TI_W-1 -: 3 * COLOR_W];
   assign inc_rd   = ti_rd[3 * LVL_W - 1:0];
   assign ti_wdata = {face_color, div_quot};

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         // final step snaps to target, other steps add the increment
         if (final_ff) lvl_new[c] = {tgt_rd[c], {FRAC_W{1'b0}}};
         else          lvl_new[c] = lvl_rd[c] + inc_rd[c];
         div_numer[c] = {1'b0, face_color[c], {FRAC_W{1'b0}}} - {1'b0, lvl_rd[c]};
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = out_valid_ff;
   assign rsp_data.pixel_index = pix_ff;
   assign rsp_data.red         = GAMMA_LUT[out_lvl_ff[2][LVL_W-1 -: COLOR_W]];
   assign rsp_data.green       = GAMMA_LUT[out_lvl_ff[1][LVL_W-1 -: COLOR_W]];
   assign rsp_data.blue        = GAMMA_LUT[out_lvl_ff[0][LVL_W-1 -: COLOR_W]];
   assign rsp_data.last        = (pix_ff == LAST_PIX);

   always_comb begin
      state_in     = state_ff;
      pix_in       = pix_ff;
      step_in      = step_ff;
      final_in     = final_ff;
      lvl_ok_in    = lvl_ok_ff;
      tgt_ok_in    = tgt_ok_ff;
      out_valid_in = out_valid_ff;
      mute_in      = mute_ff;
      rot_in       = rot_ff;
      hours_in     = hours_ff;
      minutes_in   = minutes_ff;
      seconds_in   = seconds_ff;
      out_lvl_in   = out_lvl_ff;
      lvl_we       = 1'b0;
      ti_we        = 1'b0;
      div_start    = 1'b0;

      if (csr_write) begin
         unique case (csr_index)
            CSR_MUTE:     mute_in = csr_wdata[0];
            CSR_ROTATION: rot_in  = csr_wdata;
            default:      ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_data.command == CMD_SET_TIME) begin
                  hours_in   = (req_data.hour > HOUR_MAX) ? HOUR_MAX : req_data.hour;
                  minutes_in = (req_data.minute > MIN_MAX) ? MIN_MAX : req_data.minute;
                  seconds_in = (req_data.second > MIN_MAX) ? MIN_MAX : req_data.second;
               end else begin
                  final_in = (step_ff == LAST_STEP);
                  step_in  = (step_ff == LAST_STEP) ? '0 : step_ff + 1'b1;
                  pix_in   = '0;
                  state_in = S_URD;
               end
            end
         end
         S_URD: state_in = S_UCALC;
         S_UCALC, S_UOUT: begin
            logic advance;
            advance = 1'b0;
            if (state_ff == S_UCALC) begin
               lvl_we     = 1'b1;
               out_lvl_in = lvl_new;
               if (mute_ff) begin
                  advance = 1'b1;
               end else begin
                  out_valid_in = 1'b1;
                  state_in     = S_UOUT;
               end
            end else if (rsp_ready) begin
               out_valid_in = 1'b0;
               advance      = 1'b1;
            end
            if (advance) begin
               if (pix_ff == LAST_PIX) begin
                  lvl_ok_in = 1'b1;
                  pix_in    = '0;
                  if (final_ff) begin
                     // tick with wrap at 60 / 60 / 24
                     if (seconds_ff == MIN_MAX) begin
                        seconds_in = '0;
                        if (minutes_ff == MIN_MAX) begin
                           minutes_in = '0;
                           hours_in   = (hours_ff == HOUR_MAX) ? '0 : hours_ff + 1'b1;
                        end else begin
                           minutes_in = minutes_ff + 1'b1;
                        end
                     end else begin
                        seconds_in = seconds_ff + 1'b1;
                     end
                     state_in = S_CRD;
                  end else begin
                     state_in = S_IDLE;
                  end
               end else begin
                  pix_in   = pix_ff + 1'b1;
                  state_in = S_URD;
               end
            end
         end
         S_CRD: state_in = S_CLD;
         S_CLD: begin
            div_start = 1'b1;
            state_in  = S_CDIV;
         end
         S_CDIV: begin
            if (div_done) state_in = S_CWR;
         end
         S_CWR: begin
            ti_we = 1'b1;
            if (pix_ff == LAST_PIX) begin
               tgt_ok_in = 1'b1;
               state_in  = S_IDLE;
            end else begin
               pix_in   = pix_ff + 1'b1;
               state_in = S_CRD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pix_ff       <= '0;
         step_ff      <= '0;
         final_ff     <= 1'b0;
         lvl_ok_ff    <= 1'b0;
         tgt_ok_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
         mute_ff      <= 1'b0;
         rot_ff       <= '0;
         hours_ff     <= '0;
         minutes_ff   <= '0;
         seconds_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         pix_ff       <= pix_in;
         step_ff      <= step_in;
         final_ff     <= final_in;
         lvl_ok_ff    <= lvl_ok_in;
         tgt_ok_ff    <= tgt_ok_in;
         out_valid_ff <= out_valid_in;
         mute_ff      <= mute_in;
         rot_ff       <= rot_in;
         hours_ff     <= hours_in;
         minutes_ff   <= minutes_in;
         seconds_ff   <= seconds_in;
      end
   end

   always_ff @(posedge clock) begin
      out_lvl_ff <= out_lvl_in;
   end

endmodule

// ===== tb/sv/led_ring_clock_face_crossfade_checker.sv =====
// ----------------------------------------------------------------------------
// led_ring_clock_face_crossfade_checker - pixel stream scoreboard
// follows the clock face and fade integrators beat by beat and compares
// every pixel beat field by field against the predicted frame
// ----------------------------------------------------------------------------
module led_ring_clock_face_crossfade_checker import lrcf_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  req_type          req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  rsp_type          rsp_data,
   input  logic             csr_write,
   input  logic             csr_index,
   input  logic [ROT_W-1:0] csr_wdata,
   output int               pending,
   output int               failures
);

   localparam int STEPS = FADE_STEPS_DEFAULT;

   logic            muted;
   int              rot;
   int              hh, mm, ss, phase;
   int              level [PIXEL_COUNT][3];
   int              incr  [PIXEL_COUNT][3];
   color_type       face  [PIXEL_COUNT];
   rsp_type         frame_q [$];

   function automatic void paint(int logical, color_type c);
      face[(logical + rot) % PIXEL_COUNT] = c;
   endfunction

   function automatic void compose_face();
      int hpos;
      for (int i = 0; i < PIXEL_COUNT; i++) begin
         if (i == 0) paint(i, COL_TOP);
         else if (i % 15 == 0) paint(i, COL_QUARTER);
         else if (i % 5 == 0) paint(i, COL_FIVE);
         else paint(i, COL_ELEM);
      end
      hpos = (hh % 12) * 5;
      paint(hpos, COL_HOUR);
      paint(mm, COL_MINUTE);
      paint(ss, COL_SECOND);
      if (hpos == mm) begin
         if (mm == ss) paint(ss, COL_HMS);
         else paint(mm, COL_HM);
      end else begin
         if (mm == ss) paint(mm, COL_MS);
         if (hpos == ss) paint(hpos, COL_HS);
      end
   endfunction

   function automatic void fade_step_frame();
      bit      at_end;
      rsp_type px;
      at_end = (phase == STEPS - 1);
      for (int i = 0; i < PIXEL_COUNT; i++) begin
         for (int c = 0; c < 3; c++)
            if (at_end) level[i][c] = int'(face[i][c]) * 1024;
            else level[i][c] += incr[i][c];
         if (!muted) begin
            px.pixel_index = PIX_W'(i);
            px.red         = GAMMA_LUT[(level[i][2] >>> FRAC_W) & 255];
            px.green       = GAMMA_LUT[(level[i][1] >>> FRAC_W) & 255];
            px.blue        = GAMMA_LUT[(level[i][0] >>> FRAC_W) & 255];
            px.last        = (i == PIXEL_COUNT - 1);
            frame_q.push_back(px);
         end
      end
      if (at_end) begin
         ss++;
         if (ss == 60) begin ss = 0; mm++; end
         if (mm == 60) begin mm = 0; hh++; end
         if (hh == 24) hh = 0;
         compose_face();
         // signed division truncates toward zero
         for (int i = 0; i < PIXEL_COUNT; i++)
            for (int c = 0; c < 3; c++)
               incr[i][c] = (int'(face[i][c]) * 1024 - level[i][c]) / STEPS;
      end
      phase = (phase + 1) % STEPS;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         muted = 0; rot = 0; hh = 0; mm = 0; ss = 0; phase = 0;
         failures = 0;
         for (int i = 0; i < PIXEL_COUNT; i++) begin
            face[i] = '0;
            for (int c = 0; c < 3; c++) begin level[i][c] = 0; incr[i][c] = 0; end
         end
         frame_q.delete();
      end else begin
         if (csr_write) begin
            if (csr_index == CSR_MUTE) muted = csr_wdata[0];
            else rot = int'(csr_wdata);
         end
         if (req_valid && req_ready) begin
            if (req_data.command == CMD_SET_TIME) begin
               hh = (req_data.hour > HOUR_MAX) ? HOUR_MAX : req_data.hour;
               mm = (req_data.minute > MIN_MAX) ? MIN_MAX : req_data.minute;
               ss = (req_data.second > MIN_MAX) ? MIN_MAX : req_data.second;
            end else begin
               fade_step_frame();
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (frame_q.size() == 0) begin
               $error("unexpected pixel beat, index %0d", rsp_data.pixel_index);
               failures++;
            end else begin
               want = frame_q.pop_front();
               if (rsp_data.pixel_index !== want.pixel_index) begin
                  $error("pixel_index expected %0d actual %0d",
                         want.pixel_index, rsp_data.pixel_index);
                  failures++;
               end
               if (rsp_data.red !== want.red) begin
                  $error("red expected %0d actual %0d", want.red, rsp_data.red);
                  failures++;
               end
               if (rsp_data.green !== want.green) begin
                  $error("green expected %0d actual %0d", want.green, rsp_data.green);
                  failures++;
               end
               if (rsp_data.blue !== want.blue) begin
                  $error("blue expected %0d actual %0d", want.blue, rsp_data.blue);
                  failures++;
               end
               if (rsp_data.last !== want.last) begin
                  $error("last expected %0d actual %0d", want.last, rsp_data.last);
                  failures++;
               end
            end
         end
      end
      pending = frame_q.size();
   end

endmodule

// ===== tb/sv/led_ring_clock_face_crossfade_tb.sv =====
// ----------------------------------------------------------------------------
// led_ring_clock_face_crossfade_tb - ring clock face testbench
// drives time loads and fade steps with random gaps and output stalls,
// switches mute and rotation between phases; the checker scores each pixel
// ----------------------------------------------------------------------------
module led_ring_clock_face_crossfade_tb;
   import lrcf_pkg::*;

   // a final fade step is followed by a compose and divide pass that this wait covers
   localparam int SETTLE = 1600;
   localparam int RANDOM_ITEMS = 360;

   logic             clock = 0;
   logic             reset = 1;
   logic             req_valid = 0;
   logic             req_ready;
   req_type          req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 0;
   rsp_type          rsp_data;
   logic             csr_write = 0;
   logic             csr_index = CSR_MUTE;
   logic [ROT_W-1:0] csr_wdata = '0;
   int               pending;
   int               failures;
   bit               quiet = 0;   // no idling on either side once set

   always #5 clock = ~clock;

   led_ring_clock_face_crossfade DUT (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data, .csr_write, .csr_index, .csr_wdata
   );

   led_ring_clock_face_crossfade_checker scoreboard (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data, .csr_write, .csr_index, .csr_wdata,
      .pending, .failures
   );

   // hard stop well beyond the slowest legal run
   initial begin
      #40_000_000;
      $display("Some tests failed");
      $finish;
   end

   // receiver: bursts of stall between stretches of ready
   initial begin
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (!quiet && $urandom_range(0, 2) == 0) begin
            rsp_ready <= 0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end
         rsp_ready <= 1;
         repeat ($urandom_range(1, 40)) @(posedge clock);
      end
   end

   // one beat on the request channel, with an optional gap in front
   task automatic send_beat(req_type r);
      bit took;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid <= 1;
      req_data  <= r;
      do begin
         @(negedge clock);
         took = req_ready;
         @(posedge clock);
      end while (!took);
   endtask

   task automatic set_time(int h, int m, int s);
      req_type r;
      r.command = CMD_SET_TIME;
      r.hour    = HOUR_W'(h);
      r.minute  = MIN_W'(m);
      r.second  = MIN_W'(s);
      send_beat(r);
   endtask

   task automatic fade_step();
      req_type r;
      r = req_type'($urandom);   // time fields are don't-care on a step
      r.command = CMD_STEP;
      send_beat(r);
   endtask

   // sender holds off until every pixel is out and any divide pass is done
   task automatic drain();
      req_valid <= 0;
      do @(negedge clock); while (pending != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, int val);
      csr_write <= 1;
      csr_index <= idx;
      csr_wdata <= ROT_W'(val);
      @(posedge clock);
      csr_write <= 0;
      @(posedge clock);
   endtask

   // random time load, biased toward hand coincidences and overflow values
   task automatic random_time();
      int h, m, s, hpos;
      h = $urandom_range(0, 31);
      m = $urandom_range(0, 63);
      s = $urandom_range(0, 63);
      hpos = (h % 12) * 5;
      case ($urandom_range(0, 5))
         0: begin m = hpos; s = hpos; end                 // all three together
         1: m = hpos;                                     // hour over minute
         2: s = m;                                        // minute over second
         3: s = hpos;                                     // hour over second
         default: ;
      endcase
      set_time(h, m, s);
   endtask

   initial begin
      int sent;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: both registers, overflow clamp, steps
      write_csr(CSR_MUTE, 0);
      write_csr(CSR_ROTATION, 0);
      set_time(23, 59, 59);
      fade_step();
      set_time(31, 63, 63);                 // clamps to 23:59:59
      repeat (4) fade_step();
      set_time(0, 0, 0);
      set_time(6, 30, 30);                  // hour, minute and second together
      set_time(11, 55, 10);                 // hour over minute
      set_time(4, 17, 17);                  // minute over second
      set_time(9, 3, 45);                   // hour over second
      set_time(16, 42, 33);
      repeat (8) fade_step();
      drain();
      write_csr(CSR_MUTE, 1);               // muted: fading goes on silently
      write_csr(CSR_ROTATION, 59);
      sent = 0;
      while (sent < 40) begin
         fade_step();
         sent++;
      end
      drain();
      write_csr(CSR_MUTE, 0);
      write_csr(CSR_ROTATION, 63);          // beyond 59 still wraps mod 60

      // random: mostly fade steps, sometimes a new time, config per phase
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if (sent > 0 && sent % 70 == 0) begin
            drain();
            write_csr(CSR_MUTE, $urandom_range(0, 4) == 0);
            write_csr(CSR_ROTATION, $urandom_range(0, 63));
         end
         if (sent == RANDOM_ITEMS - 60) begin
            drain();
            write_csr(CSR_MUTE, 0);
            write_csr(CSR_ROTATION, $urandom_range(0, 59));
            quiet = 1;
         end
         if ($urandom_range(0, 9) == 0) random_time();
         else fade_step();
         sent++;
      end
      req_valid <= 0;

      do @(negedge clock); while (pending != 0);
      repeat (SETTLE) @(posedge clock);
      if (failures == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
